@@ hdl/armg_pkg.sv @@
// ----------------------------------------------------------------------------
// armg_pkg
// Types, fixed-point constants and the CORDIC arctangent table shared by the
// axis rotation matrix generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package armg_pkg;

    // datapath widths: x/y carry some headroom over Q1.30, z covers +-2^32 counts
    localparam int XY_W = 34;
    localparam int Z_W  = 33;

    localparam logic signed [31:0]     Q_ONE       = 32'sd1073741824;
    localparam logic signed [XY_W-1:0] Q_ONE_XY    = 34'sd1073741824;
    localparam logic signed [XY_W-1:0] Q_MONE_XY   = -34'sd1073741824;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  Z_OFFSET    = 33'sd536870912;
    localparam logic [31:0]            QUARTER_RND = 32'h2000_0000;

    // axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] angle;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } result_t;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // clamp to [-1.0, 1.0] in Q1.30
    function automatic logic signed [31:0] sat_q(input logic signed [XY_W-1:0] v);
        logic signed [31:0] r;
        if (v > Q_ONE_XY) begin
            r = Q_ONE;
        end else if (v < Q_MONE_XY) begin
            r = -Q_ONE;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/axis_rotation_matrix_gen.sv @@
// ----------------------------------------------------------------------------
// axis_rotation_matrix_gen
// Elementary 3x3 rotation matrix about x, y or z from a binary angle, using a
// fully pipelined CORDIC for cosine and sine; cells in Q1.30.
// ----------------------------------------------------------------------------
// One transaction enters on every clock where start is high; busy is always
// low because nothing downstream can hold results off. The accepting edge
// loads the angle reduction register, then the matrix passes through the
// CORDIC rotation stages, one register each, and a final register that
// holds the saturated, quadrant-fixed and assembled matrix and drives done.
// done stays high for exactly one cycle per matrix, and the matrix on
// result is valid while done is high.
// Throughput is one matrix per clock.
// The angle is a 32-bit binary angle (2^32 counts per turn) of which the top
// ANGLE_BITS bits are used. Axis code 0 is x, 1 is y, 2 is z, 3 the identity.
`timescale 1ns / 1ps
`default_nettype none

module axis_rotation_matrix_gen
    import armg_pkg::*;
#(
    parameter int CORDIC_STAGES = 30,
    parameter int ANGLE_BITS    = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire cmd_t    cmd,
    output logic         done,
    output result_t      result
);

    localparam int LATENCY = CORDIC_STAGES + 2;
    localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

    // per-stage pipeline registers; index 0 is the reduced input
    logic signed [XY_W-1:0] x_reg     [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] y_reg     [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_reg     [0:CORDIC_STAGES];
    logic [1:0]             q_reg     [0:CORDIC_STAGES];
    logic [1:0]             axis_reg  [0:CORDIC_STAGES];
    logic                   valid_reg [0:CORDIC_STAGES];

    logic                   accept;
    logic [31:0]            ang_masked;
    logic [31:0]            ang_shift;
    logic signed [Z_W-1:0]  z_next;

    result_t                result_reg;
    result_t                result_next;
    logic                   done_reg;

    // pipeline runs freely, so it is never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------- input stage: quarter-turn split ----------------
    // q = round-half-up(angle / quarter turn), residual within +-45 degrees
    always_comb
    begin
        ang_masked = cmd.angle & ANGLE_MASK;
        ang_shift  = ang_masked + QUARTER_RND;
        z_next     = $signed({3'b000, ang_shift[29:0]}) - Z_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= z_next;
        q_reg[0]    <= ang_shift[31:30];
        axis_reg[0] <= cmd.axis;
    end

    // ---------------- CORDIC rotation stages ----------------
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_stage
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  atan_val;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  zs_next;

        always_comb
        begin
            dx       = y_reg[g] >>> g;
            dy       = x_reg[g] >>> g;
            atan_val = $signed({1'b0, atan_entry(5'(g))});
            // non-negative residual rotates counterclockwise
            if (!z_reg[g][Z_W-1])
            begin
                x_next  = x_reg[g] - dx;
                y_next  = y_reg[g] + dy;
                zs_next = z_reg[g] - atan_val;
            end
            else
            begin
                x_next  = x_reg[g] + dx;
                y_next  = y_reg[g] - dy;
                zs_next = z_reg[g] + atan_val;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[g+1]    <= x_next;
            y_reg[g+1]    <= y_next;
            z_reg[g+1]    <= zs_next;
            q_reg[g+1]    <= q_reg[g];
            axis_reg[g+1] <= axis_reg[g];
        end
    end

    // ---------------- output stage: saturate, quadrant, matrix ----------------
    logic signed [31:0] c_sat;
    logic signed [31:0] s_sat;
    logic signed [31:0] c_val;
    logic signed [31:0] s_val;

    always_comb
    begin
        c_sat = sat_q(x_reg[CORDIC_STAGES]);
        s_sat = sat_q(y_reg[CORDIC_STAGES]);

        // turn (c, s) by q quarter turns
        case (q_reg[CORDIC_STAGES])
            2'd0:
            begin
                c_val = c_sat;
                s_val = s_sat;
            end
            2'd1:
            begin
                c_val = -s_sat;
                s_val = c_sat;
            end
            2'd2:
            begin
                c_val = -c_sat;
                s_val = -s_sat;
            end
            default:
            begin
                c_val = s_sat;
                s_val = -c_sat;
            end
        endcase

        // start from identity, then drop in the rotation block
        result_next     = '0;
        result_next.m00 = Q_ONE;
        result_next.m11 = Q_ONE;
        result_next.m22 = Q_ONE;
        unique case (axis_reg[CORDIC_STAGES])
            AXIS_X:
            begin
                result_next.m11 = c_val;
                result_next.m12 = -s_val;
                result_next.m21 = s_val;
                result_next.m22 = c_val;
            end
            AXIS_Y:
            begin
                result_next.m00 = c_val;
                result_next.m02 = s_val;
                result_next.m20 = -s_val;
                result_next.m22 = c_val;
            end
            AXIS_Z:
            begin
                result_next.m00 = c_val;
                result_next.m01 = -s_val;
                result_next.m10 = s_val;
                result_next.m11 = c_val;
            end
            AXIS_NONE:
            begin
                result_next.m00 = Q_ONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // every accepted transaction produces a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction did not produce a result on time");

    // no result strobe without a matching accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching transaction");

    // diagonal cells stay within the saturated Q1.30 range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.m00 <= Q_ONE && result.m00 >= -Q_ONE
                  && result.m11 <= Q_ONE && result.m11 >= -Q_ONE
                  && result.m22 <= Q_ONE && result.m22 >= -Q_ONE))
        else $error("matrix cell outside [-1, 1]");
`endif

endmodule

`default_nettype wire

@@ tb/armg_matrix_checker.sv @@
// ----------------------------------------------------------------------------
// armg_matrix_checker
// Watches the command and result channels of the rotation matrix generator,
// predicts each matrix with its own CORDIC and compares it cell by cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module armg_matrix_checker
    import armg_pkg::*;
#(
    parameter int CORDIC_STAGES = 30,
    parameter int ANGLE_BITS    = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  cmd_t    cmd,
    input  logic    done,
    input  result_t result,
    output int      errors,
    output int      pending
);

    localparam int  NUM_CELLS   = 9;
    localparam int  CELL_W      = 32;
    localparam int  RESULT_W    = NUM_CELLS * CELL_W;

    localparam logic signed [31:0] UNIT_Q30  = 32'sh4000_0000;
    localparam longint             UNIT_WIDE = 64'sd1073741824;
    localparam longint             START_X   = 64'sd652032874;

    result_t expected_matrices[$];
    cmd_t    expected_cmds[$];
    longint  atan_turns [0:31];
    string   cell_names [0:NUM_CELLS-1];
    int      mismatch_count;

    initial
    begin
        atan_turns = '{
            536870912, 316933406, 167458907, 85004756,
            42667331,  21354465,  10679838,  5340245,
            2670163,   1335087,   667544,    333772,
            166886,    83443,     41722,     20861,
            10430,     5215,      2608,      1304,
            652,       326,       163,       81,
            41,        20,        10,        5,
            3,         1,         1,         0
        };
        cell_names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    end

    function automatic logic signed [31:0] clamp_unit(input longint v);
        logic signed [31:0] r;
        if (v > UNIT_WIDE)
        begin
            r = UNIT_Q30;
        end
        else if (v < -UNIT_WIDE)
        begin
            r = -UNIT_Q30;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic result_t predict_matrix(input cmd_t c);
        logic [31:0]        keep_mask;
        logic [31:0]        shifted;
        logic [1:0]         quadrant;
        longint             x;
        longint             y;
        longint             z;
        longint             dx;
        longint             dy;
        logic signed [31:0] cr;
        logic signed [31:0] sr;
        logic signed [31:0] cq;
        logic signed [31:0] sq;
        result_t            m;
        keep_mask = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
        shifted   = (c.angle & keep_mask) + 32'h2000_0000;
        quadrant  = shifted[31:30];
        z = longint'(shifted[29:0]) - 64'sd536870912;
        x = START_X;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turns[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turns[i];
            end
        end
        cr = clamp_unit(x);
        sr = clamp_unit(y);
        case (quadrant)
            2'd0:    begin cq = cr;  sq = sr;  end
            2'd1:    begin cq = -sr; sq = cr;  end
            2'd2:    begin cq = -cr; sq = -sr; end
            default: begin cq = sr;  sq = -cr; end
        endcase
        m     = '0;
        m.m00 = UNIT_Q30;
        m.m11 = UNIT_Q30;
        m.m22 = UNIT_Q30;
        case (c.axis)
            AXIS_X:
            begin
                m.m11 = cq;  m.m12 = -sq;
                m.m21 = sq;  m.m22 = cq;
            end
            AXIS_Y:
            begin
                m.m00 = cq;  m.m02 = sq;
                m.m20 = -sq; m.m22 = cq;
            end
            AXIS_Z:
            begin
                m.m00 = cq;  m.m01 = -sq;
                m.m10 = sq;  m.m11 = cq;
            end
            default: ;
        endcase
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t            want;
        cmd_t               origin;
        logic signed [31:0] want_cell;
        logic signed [31:0] got_cell;
        if (!rst_n)
        begin
            expected_matrices.delete();
            expected_cmds.delete();
            mismatch_count = 0;
            pending        = 0;
        end
        else
        begin
            // results come out in order, so check before logging a new command
            if (done)
            begin
                if (expected_matrices.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result);
                end
                else
                begin
                    want   = expected_matrices.pop_front();
                    origin = expected_cmds.pop_front();
                    for (int k = 0; k < NUM_CELLS; k++)
                    begin
                        want_cell = want[RESULT_W-1-CELL_W*k -: CELL_W];
                        got_cell  = result[RESULT_W-1-CELL_W*k -: CELL_W];
                        if (want_cell !== got_cell)
                        begin
                            mismatch_count++;
                            $display("%0t: %s axis %0d angle %h expected %0d actual %0d",
                                     $time, cell_names[k], origin.axis, origin.angle,
                                     want_cell, got_cell);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                expected_matrices.push_back(predict_matrix(cmd));
                expected_cmds.push_back(cmd);
            end
            pending = expected_matrices.size();
        end
    end

    assign errors = mismatch_count;

endmodule

@@ tb/axis_rotation_matrix_gen_tb.sv @@
// ----------------------------------------------------------------------------
// axis_rotation_matrix_gen_tb
// Drives angle and axis commands into the rotation matrix generator: a
// directed set of angles around the quadrant seams and the extremes, then
// random commands under three idling profiles. A checker beside the block
// predicts every matrix and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_rotation_matrix_gen_tb;

    import armg_pkg::*;

    localparam int CORDIC_STAGES  = 30;
    localparam int ANGLE_BITS     = 32;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int PIPE_LATENCY   = CORDIC_STAGES + 2;
    localparam int DRAIN_CYCLES   = PIPE_LATENCY + 8;
    // longest legal quiet stretch is a sender gap or a full pipeline drain
    localparam int WATCHDOG_LIMIT = 20 * PIPE_LATENCY;
    localparam int PHASE_ITEMS    = 650;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    int      error_count;
    int      pending_count;
    int      quiet_cycles;

    axis_rotation_matrix_gen #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // checker sits on the same wires; it never drives the block
    armg_matrix_checker #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .errors  (error_count),
        .pending (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // watchdog: counts cycles with neither a command taken nor a result out
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending_count);
            $display("** axis_rotation_matrix_gen: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one transaction: first the gap idle steps (start low, noise on cmd), then
    // present the command at a falling edge and hold it until it is taken.
    // start stays high into the next transaction when gap is zero, so it is
    // never lowered and raised in the same step
    task automatic send_cmd(input cmd_t c, input int gap);
        for (int g = 0; g < gap; g++)
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= {2'($urandom_range(0, 3)), $urandom()};
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // sender stops and lets the pipeline empty out completely
    task automatic wait_drained;
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    // angles cluster where the block is most fragile: the rounding seam at
    // odd multiples of 45 degrees, exact quarter turns, tiny angles and the
    // ends of the signed range or one count off zero; the rest is uniform over the whole word
    function automatic cmd_t random_cmd();
        cmd_t        c;
        int unsigned pick;
        logic [31:0] base;
        pick   = $urandom_range(0, 9);
        c.axis = 2'($urandom_range(0, 3));
        case (pick)
            0, 1, 2, 3:
            begin
                c.angle = $urandom();
            end
            4, 5:
            begin
                base    = {2'($urandom_range(0, 3)), 30'h2000_0000};
                c.angle = base + 32'($signed($urandom_range(0, 64)) - 32);
            end
            6, 7:
            begin
                base    = {2'($urandom_range(0, 3)), 30'h0};
                c.angle = base + 32'($signed($urandom_range(0, 2048)) - 1024);
            end
            8:
            begin
                c.angle = 32'($signed($urandom_range(0, 65536)) - 32768);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       c.angle = 32'h7FFF_FFFF;
                    1:       c.angle = 32'h8000_0000;
                    2:       c.angle = 32'hFFFF_FFFF;
                    default: c.angle = 32'h0000_0001;
                endcase
            end
        endcase
        return c;
    endfunction

    // random phase: before each command the sender idles cycle by cycle,
    // every cycle idle with a chance of idle_pct in a hundred
    task automatic run_random(input int items, input int idle_pct);
        int gap;
        for (int n = 0; n < items; n++)
        begin
            gap = 0;
            while ($urandom_range(0, 99) < idle_pct)
            begin
                gap++;
            end
            send_cmd(random_cmd(), gap);
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] seam_angles [0:7];
        cmd_t        c;
        seam_angles = '{
            32'h0000_0000,  // zero, cosine gain overshoot is clamped to one
            32'h4000_0000,  // quarter turn
            32'h8000_0000,  // half turn, most negative angle
            32'hC000_0000,  // minus quarter turn
            32'h2000_0000,  // 45 degrees, rounds up into the next quadrant
            32'h1FFF_FFFF,  // just below the 45 degree seam
            32'h7FFF_FFFF,  // most positive angle
            32'hFFFF_FFFF   // one count below zero
        };
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every rotation axis against every seam angle
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                c.axis  = 2'(a);
                c.angle = seam_angles[k];
                send_cmd(c, k % 3);
            end
        end
        // identity ignores the angle entirely
        c.axis  = AXIS_NONE;
        c.angle = 32'h8000_0000;
        send_cmd(c, 0);
        wait_drained();

        // sender idles about a quarter of the time
        run_random(PHASE_ITEMS, 27);
        wait_drained();
        // sender idles more often than not
        run_random(PHASE_ITEMS, 60);
        wait_drained();
        // back to back
        run_random(PHASE_ITEMS, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
        begin
            $display("** axis_rotation_matrix_gen: PASSED **");
        end
        else
        begin
            $display("** axis_rotation_matrix_gen: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/armg_pkg.sv
hdl/axis_rotation_matrix_gen.sv
tb/armg_matrix_checker.sv
tb/axis_rotation_matrix_gen_tb.sv
